// File: rtl/itp_pkg.sv
// Shared types, character codes and precedence table for the infix-to-postfix converter.
// No dependencies; imported by the top level and the testbench.
`default_nettype none

package itp_pkg;

    // Operator stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int CHAR_W      = 8;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_POW   = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Error codes on the final result of a run
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNMATCHED = 2'd2
    } t_err;

    // Operator precedence: additive 1, multiplicative 2, power 3, anything else 0
    function automatic logic [1:0] prec(input logic [CHAR_W-1:0] c);
        logic [1:0] p;
        case (c)
            CH_PLUS, CH_MINUS: p = 2'd1;
            CH_MUL, CH_DIV:    p = 2'd2;
            CH_POW:            p = 2'd3;
            default:           p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: rtl/itp_ram.sv
// Generic single-write, single-read RAM with registered, enabled read data.
// No dependencies.
`default_nettype none

module itp_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; hold data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/infix_to_postfix_stack_converter.sv
// Shunting-yard infix-to-postfix converter, top level and control sequencer.
// Depends on itp_pkg and itp_ram (operator stack memory).
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  input    | i_valid / o_ready  | i_in_char, i_end_of_expr
//  output   | o_valid / i_ready  | o_out_char, o_char_valid, o_last, o_error_code
//
// A '(' push and an operator pushed onto an empty stack finish in S_IDLE; a digit or
// an overflowing '(' goes on to S_DONE. Any other item runs S_POP for each pop and
// ends in S_DONE when it empties the stack, or after first reading a top that stops
// it (the matching bracket or a weaker operator); S_DONE waits for the output to drain.
// Reset (synchronous, active low) empties the stack; no clearing pass is run.
// The result register lets the sequencer keep working while a result waits;
// a full result register stalls the sequencer only when it must emit.
`default_nettype none

module infix_to_postfix_stack_converter (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [itp_pkg::CHAR_W-1:0] i_in_char,
    input  wire logic                       i_end_of_expr,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [itp_pkg::CHAR_W-1:0] o_out_char,
    output logic                            o_char_valid,
    output logic                            o_last,
    output logic      [1:0]                 o_error_code
);

    import itp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        MODE_END   = 2'd0,
        MODE_CLOSE = 2'd1,
        MODE_OPER  = 2'd2
    } t_mode;

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    t_err                r_err, n_err;
    logic                r_force, n_force;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_pend_valid, n_pend_valid;
    logic [CHAR_W-1:0]   r_pend_char, n_pend_char;

    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_char_valid;
    logic                r_out_last;
    t_err                r_out_err;

    logic                out_load;
    logic [CHAR_W-1:0]   out_char;
    logic                out_char_valid;
    logic                out_last;
    t_err                out_err;
    logic                out_free;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CHAR_W-1:0]   rd_data;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CHAR_W-1:0]   wr_data;

    logic [CNT_W-1:0]    cnt_m1, cnt_m2;
    logic                full;
    logic                is_digit;
    logic                top_stop;
    logic                can_emit;

    // Operator stack storage
    itp_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign cnt_m1   = r_count - CNT_W'(1);
    assign cnt_m2   = r_count - CNT_W'(2);
    assign full     = (r_count == CNT_W'(STACK_DEPTH));
    assign is_digit = (i_in_char >= CH_ZERO) && (i_in_char <= CH_NINE);
    assign out_free = !r_out_valid || i_ready;
    assign can_emit = !r_pend_valid || out_free;

    // Stop popping when the top is the matching bracket or binds weaker
    always_comb begin
        top_stop = 1'b0;
        case (r_mode)
            MODE_CLOSE: top_stop = (rd_data == CH_OPEN);
            MODE_OPER:  top_stop = (rd_data == CH_OPEN) || (prec(rd_data) < prec(r_char));
            default:    top_stop = 1'b0;
        endcase
    end

    // Sequencer: decode the request, pop through the stack, close the run
    always_comb begin
        n_state        = r_state;
        n_mode         = r_mode;
        n_err          = r_err;
        n_force        = r_force;
        n_count        = r_count;
        n_char         = r_char;
        n_pend_valid   = r_pend_valid;
        n_pend_char    = r_pend_char;
        out_load       = 1'b0;
        out_char       = r_pend_char;
        out_char_valid = 1'b1;
        out_last       = 1'b0;
        out_err        = ERR_NONE;
        rd_en          = 1'b0;
        rd_addr        = cnt_m1[ADDR_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = r_count[ADDR_W-1:0];
        wr_data        = r_char;
        o_ready        = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_char  = i_in_char;
                    n_err   = ERR_NONE;
                    n_force = 1'b0;
                    wr_data = i_in_char;
                    if (i_end_of_expr) begin
                        n_mode  = MODE_END;
                        n_force = 1'b1;
                        if (r_count == '0) begin
                            n_state = S_DONE;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_POP;
                        end
                    end else if (is_digit) begin
                        n_pend_valid = 1'b1;
                        n_pend_char  = i_in_char;
                        n_state      = S_DONE;
                    end else if (i_in_char == CH_OPEN) begin
                        if (full) begin
                            n_err   = ERR_OVERFLOW;
                            n_force = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end else if (i_in_char == CH_CLOSE) begin
                        n_mode = MODE_CLOSE;
                        if (r_count == '0) begin
                            n_err   = ERR_UNMATCHED;
                            n_force = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_POP;
                        end
                    end else begin
                        n_mode = MODE_OPER;
                        if (r_count == '0) begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_POP;
                        end
                    end
                end
            end

            S_POP: begin
                if (top_stop) begin
                    n_state = S_DONE;
                    if (r_mode == MODE_CLOSE) begin
                        // drop the matching open bracket
                        n_count = cnt_m1;
                    end else if (full) begin
                        n_err   = ERR_OVERFLOW;
                        n_force = 1'b1;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end else if (can_emit) begin
                    // advance the held result to the output, hold the new one
                    if (r_pend_valid) begin
                        out_load = 1'b1;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_char  = rd_data;
                    n_count      = cnt_m1;
                    if (cnt_m1 == '0) begin
                        n_state = S_DONE;
                        case (r_mode)
                            MODE_CLOSE: begin
                                n_err   = ERR_UNMATCHED;
                                n_force = 1'b1;
                            end
                            MODE_OPER: begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                n_count = r_count;
                            end
                            default: ;
                        endcase
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = cnt_m2[ADDR_W-1:0];
                    end
                end
            end

            S_DONE: begin
                if (r_pend_valid || r_force) begin
                    if (out_free) begin
                        out_load       = 1'b1;
                        out_char       = r_pend_valid ? r_pend_char : '0;
                        out_char_valid = r_pend_valid;
                        out_last       = 1'b1;
                        out_err        = r_err;
                        n_pend_valid   = 1'b0;
                        n_force        = 1'b0;
                        n_state        = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_force      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_force      <= n_force;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_err       <= n_err;
        r_char      <= n_char;
        r_pend_char <= n_pend_char;
        if (out_load) begin
            r_out_char       <= out_char;
            r_out_char_valid <= out_char_valid;
            r_out_last       <= out_last;
            r_out_err        <= out_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_char_valid = r_out_char_valid;
    assign o_last       = r_out_last;
    assign o_error_code = r_out_err;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the shunting-yard infix-to-postfix converter.
// Depends on itp_pkg and the converter RTL; predicts the postfix stream per character request.

module tb_top;
    import itp_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              vld;
        logic              last;
        t_err              err;
    } post_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eoe;
    } req_t;

    typedef struct packed {
        req_t  req;
        logic  typed;
        post_t want;
    } row_t;

    typedef enum logic [1:0] {
        SEQ_WELL,
        SEQ_DEEP,
        SEQ_BROKEN,
        SEQ_NOISE
    } seq_kind_t;

    localparam int RAND_PER_PHASE = 80;
    localparam int DRAIN_CYCLES   = STACK_DEPTH + 16;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic [CHAR_W-1:0] i_in_char     = '0;
    logic              i_end_of_expr = 1'b0;
    logic              i_ready       = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [CHAR_W-1:0] o_out_char;
    logic              o_char_valid;
    logic              o_last;
    logic [1:0]        o_error_code;

    // Predictor state: operator stack and its fill level
    logic [CHAR_W-1:0] op_stack [STACK_DEPTH];
    int                op_depth = 0;

    post_t postfix_q [$];
    post_t step_q    [$];
    req_t  seq_q     [$];
    row_t  dir_tab   [$];

    int send_idle  = 0;
    int recv_stall = 0;
    int req_cnt    = 0;
    int res_cnt    = 0;
    int ovf_cnt    = 0;
    int unm_cnt    = 0;
    int fail_cnt   = 0;

    infix_to_postfix_stack_converter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_char     (i_in_char),
        .i_end_of_expr (i_end_of_expr),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_char_valid  (o_char_valid),
        .o_last        (o_last),
        .o_error_code  (o_error_code)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Binding strength of an operator; anything unknown binds loosest
    function automatic logic [1:0] rank(input logic [CHAR_W-1:0] c);
        if (c == CH_POW) return 2'd3;
        if (c == CH_MUL || c == CH_DIV) return 2'd2;
        if (c == CH_PLUS || c == CH_MINUS) return 2'd1;
        return 2'd0;
    endfunction

    function automatic post_t emit(input logic [CHAR_W-1:0] c, input logic v);
        post_t r;
        r.ch   = c;
        r.vld  = v;
        r.last = 1'b0;
        r.err  = ERR_NONE;
        return r;
    endfunction

    function automatic t_err stack_push(input logic [CHAR_W-1:0] c);
        if (op_depth >= STACK_DEPTH) return ERR_OVERFLOW;
        op_stack[op_depth] = c;
        op_depth++;
        return ERR_NONE;
    endfunction

    // Advance the predictor by one request; results land in step_q
    function automatic void shunt_char(input req_t r);
        t_err err;
        logic found;
        err   = ERR_NONE;
        found = 1'b0;
        step_q.delete();
        if (r.eoe) begin
            while (op_depth > 0) begin
                op_depth--;
                step_q.push_back(emit(op_stack[op_depth], 1'b1));
            end
            if (step_q.size() == 0) step_q.push_back(emit('0, 1'b0));
        end else if (r.ch >= CH_ZERO && r.ch <= CH_NINE) begin
            step_q.push_back(emit(r.ch, 1'b1));
        end else if (r.ch == CH_OPEN) begin
            err = stack_push(r.ch);
        end else if (r.ch == CH_CLOSE) begin
            while (op_depth > 0 && !found) begin
                op_depth--;
                if (op_stack[op_depth] == CH_OPEN) found = 1'b1;
                else step_q.push_back(emit(op_stack[op_depth], 1'b1));
            end
            if (!found) err = ERR_UNMATCHED;
        end else begin
            // pop while the top binds at least as tightly, stopping at an open bracket
            while (op_depth > 0 && op_stack[op_depth-1] != CH_OPEN
                   && rank(op_stack[op_depth-1]) >= rank(r.ch)) begin
                op_depth--;
                step_q.push_back(emit(op_stack[op_depth], 1'b1));
            end
            err = stack_push(r.ch);
        end
        if (err != ERR_NONE && step_q.size() == 0) step_q.push_back(emit('0, 1'b0));
        if (step_q.size() > 0) begin
            step_q[step_q.size()-1].last = 1'b1;
            step_q[step_q.size()-1].err  = err;
        end
    endfunction

    function automatic req_t mk_req(input logic [CHAR_W-1:0] c, input logic e);
        req_t r;
        r.ch  = c;
        r.eoe = e;
        return r;
    endfunction

    function automatic row_t mk_row(input logic [CHAR_W-1:0] c, input logic e,
                                    input logic typed, input logic [CHAR_W-1:0] wch,
                                    input logic wvld, input t_err werr);
        row_t r;
        r.req       = mk_req(c, e);
        r.typed     = typed;
        r.want      = emit(wch, wvld);
        r.want.last = 1'b1;
        r.want.err  = werr;
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_digit();
        return CH_ZERO + CHAR_W'($urandom_range(9));
    endfunction

    // Mostly real operators, now and then a loose-binding stray character
    function automatic logic [CHAR_W-1:0] pick_op();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(5))
            0: c = CH_PLUS;
            1: c = CH_MINUS;
            2: c = CH_MUL;
            3: c = CH_DIV;
            4: c = CH_POW;
            default: begin
                c = CHAR_W'($urandom_range(255));
                if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_OPEN || c == CH_CLOSE)
                    c = CH_POW;
            end
        endcase
        return c;
    endfunction

    function automatic seq_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 55) return SEQ_WELL;
        if (r < 70) return SEQ_DEEP;
        if (r < 85) return SEQ_BROKEN;
        return SEQ_NOISE;
    endfunction

    // Fill seq_q with one expression's worth of requests
    task automatic build_seq(input seq_kind_t kind);
        int n;
        int depth;
        seq_q.delete();
        case (kind)
            SEQ_DEEP: begin
                // pile up 30 to 40 open brackets, mostly past the stack size, to provoke an overflow
                n = $urandom_range(30, 40);
                repeat (n)
                    seq_q.push_back(mk_req(($urandom_range(9) == 0) ? pick_op() : CH_OPEN,
                                           1'b0));
                repeat ($urandom_range(3)) begin
                    case ($urandom_range(2))
                        0:       seq_q.push_back(mk_req(pick_digit(), 1'b0));
                        1:       seq_q.push_back(mk_req(CH_CLOSE, 1'b0));
                        default: seq_q.push_back(mk_req(pick_op(), 1'b0));
                    endcase
                end
                seq_q.push_back(mk_req(CHAR_W'($urandom_range(255)), 1'b1));
            end
            SEQ_NOISE: begin
                repeat ($urandom_range(1, 8))
                    seq_q.push_back(mk_req(CHAR_W'($urandom_range(255)),
                                           $urandom_range(7) == 0));
            end
            default: begin
                n     = $urandom_range(1, 10);
                depth = 0;
                for (int i = 0; i < n; i++) begin
                    while ($urandom_range(3) == 0) begin
                        seq_q.push_back(mk_req(CH_OPEN, 1'b0));
                        depth++;
                    end
                    seq_q.push_back(mk_req(pick_digit(), 1'b0));
                    while (depth > 0 && $urandom_range(2) == 0) begin
                        seq_q.push_back(mk_req(CH_CLOSE, 1'b0));
                        depth--;
                    end
                    if (i != n - 1) seq_q.push_back(mk_req(pick_op(), 1'b0));
                end
                while (depth > 0) begin
                    seq_q.push_back(mk_req(CH_CLOSE, 1'b0));
                    depth--;
                end
                seq_q.push_back(mk_req(CHAR_W'($urandom_range(255)), 1'b1));
                // break it: stray close bracket, a corrupted character, maybe no end mark
                if (kind == SEQ_BROKEN) begin
                    seq_q.insert($urandom_range(seq_q.size() - 1), mk_req(CH_CLOSE, 1'b0));
                    seq_q[$urandom_range(seq_q.size() - 1)].ch = CHAR_W'($urandom_range(255));
                    if ($urandom_range(2) == 0) void'(seq_q.pop_back());
                end
            end
        endcase
    endtask

    // Present one request, hold it until accepted, then log its expected results
    task automatic send_req(input req_t r, input logic typed = 1'b0, input post_t want = '0);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_in_char     <= r.ch;
        i_end_of_expr <= r.eoe;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        shunt_char(r);
        if (typed) postfix_q.push_back(want);
        else foreach (step_q[k]) postfix_q.push_back(step_q[k]);
        req_cnt++;
        @(negedge i_clk);
    endtask

    // Receiver backpressure
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall);
    end

    // Compare each delivered result against the oldest expectation
    always @(posedge i_clk) begin
        post_t got;
        post_t want;
        if (i_rst_n && o_valid && i_ready) begin
            got.ch   = o_out_char;
            got.vld  = o_char_valid;
            got.last = o_last;
            got.err  = t_err'(o_error_code);
            res_cnt++;
            if (got.err == ERR_OVERFLOW) ovf_cnt++;
            if (got.err == ERR_UNMATCHED) unm_cnt++;
            if (postfix_q.size() == 0) begin
                $display("%0t: unexpected result char=%h valid=%b last=%b err=%0d",
                         $time, got.ch, got.vld, got.last, got.err);
                fail_cnt++;
            end else begin
                want = postfix_q.pop_front();
                if (got.ch !== want.ch || got.vld !== want.vld || got.last !== want.last
                    || got.err !== want.err) begin
                    $display({"%0t: expected char=%h valid=%b last=%b err=%0d,",
                              " got char=%h valid=%b last=%b err=%0d"},
                             $time, want.ch, want.vld, want.last, want.err,
                             got.ch, got.vld, got.last, got.err);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        int   ph;
        logic first;

        // hold reset at start, then release it
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: typed where the result is obvious, else predicted
        dir_tab.push_back(mk_row(8'h00,    1'b1, 1'b1, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(CH_CLOSE, 1'b0, 1'b1, 8'h00,   1'b0, ERR_UNMATCHED));
        dir_tab.push_back(mk_row(CH_ZERO,  1'b0, 1'b1, CH_ZERO, 1'b1, ERR_NONE));
        dir_tab.push_back(mk_row(CH_NINE,  1'b0, 1'b1, CH_NINE, 1'b1, ERR_NONE));
        dir_tab.push_back(mk_row(8'h00,    1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(8'hFF,    1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(CH_OPEN,  1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        // power right on an open bracket: no pop
        dir_tab.push_back(mk_row(CH_POW,   1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(CH_PLUS,  1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(CH_MINUS, 1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(CH_MUL,   1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(CH_DIV,   1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(CH_POW,   1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(CH_CLOSE, 1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        // leftover open bracket flushed as a plain character
        dir_tab.push_back(mk_row(CH_OPEN,  1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(CH_NINE,  1'b1, 1'b0, 8'h00,   1'b0, ERR_NONE));
        // unmatched close bracket over a non-empty stack
        dir_tab.push_back(mk_row(CH_PLUS,  1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(CH_CLOSE, 1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(8'h3A,    1'b0, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(CH_NINE,  1'b1, 1'b0, 8'h00,   1'b0, ERR_NONE));
        dir_tab.push_back(mk_row(8'hFF,    1'b1, 1'b1, 8'h00,   1'b0, ERR_NONE));

        foreach (dir_tab[k]) send_req(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].want);

        // Random expressions over four idling phases
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 68; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 68; end
                default: begin send_idle = 11; recv_stall = 11; end
            endcase
            first = 1'b1;
            while (req_cnt < dir_tab.size() + (ph + 1) * RAND_PER_PHASE) begin
                build_seq(first ? SEQ_DEEP : pick_kind());
                first = 1'b0;
                foreach (seq_q[k]) send_req(seq_q[k]);
            end
            // hold off new requests until every expected result is back
            i_valid <= 1'b0;
            while (postfix_q.size() != 0) @(negedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d character requests across four idling phases, checked %0d results",
                 req_cnt, res_cnt);
        $display("Error flags seen: %0d stack overflow, %0d unmatched close bracket",
                 ovf_cnt, unm_cnt);
        if (fail_cnt == 0 && postfix_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (postfix_q.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, postfix_q.size());
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("%0t: timeout, converter stopped making progress", $time);
        $display("Mismatches found");
        $finish;
    end

endmodule
